// ===== rtl/core/spq_pkg.sv =====
package spq_pkg;

    localparam int IdWidth       = 16;
    localparam int PriorityWidth = 8;
    localparam int StatusWidth   = 2;
    localparam int OccWidth      = 4;

    typedef logic [StatusWidth-1:0] status_t;

    localparam status_t STATUS_INSERTED = 2'd0;
    localparam status_t STATUS_REMOVED  = 2'd1;
    localparam status_t STATUS_FULL     = 2'd2;
    localparam status_t STATUS_EMPTY    = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Command from the controller to the datapath for one accepted item.
    typedef struct packed {
        logic    load;
        logic    insert;
        logic    remove;
        status_t status;
    } cmd_t;

    // Queue condition reported by the datapath.
    typedef struct packed {
        logic full;
        logic empty;
    } flags_t;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH jobs, smallest priority value at the
// front. Each input transfer is an insert (mode 0) or a remove (mode 1) and
// produces exactly one output transfer carrying a status code, the removed
// job on a successful remove (zero otherwise), and the job count afterward.
// Jobs of equal priority leave in arrival order. An insert into a full queue
// and a remove from an empty queue are rejected and leave the queue as it was.
// For each item the whole row of storage cells compares against the new
// priority and shifts as the item is accepted, so the block sustains one
// input transfer per cycle for as long as results are taken. The result
// register is the only buffer, so a stalled output holds the next input back.
// The storage needs no clearing after reset; only the job count and output state are reset.
module sorted_priority_queue #(
    parameter int DEPTH = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Input channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              mode,
    input  logic [spq_pkg::IdWidth-1:0]       job_id,
    input  logic [spq_pkg::PriorityWidth-1:0] job_priority,

    // Output channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [spq_pkg::StatusWidth-1:0]   status,
    output logic [spq_pkg::IdWidth-1:0]       out_id,
    output logic [spq_pkg::PriorityWidth-1:0] out_priority,
    output logic [spq_pkg::OccWidth-1:0]      occupancy
);

    spq_pkg::cmd_t   cmd;
    spq_pkg::flags_t flags;

    // The controller owns the handshake and decides what each item does.
    spq_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mode      (mode),
        .flags     (flags),
        .cmd       (cmd)
    );

    // The datapath holds the sorted cells, the count and the result register.
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .job_id       (job_id),
        .job_priority (job_priority),
        .flags        (flags),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

endmodule

// ===== rtl/core/spq_controller.sv =====
module spq_controller (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  logic            mode,
    input  spq_pkg::flags_t flags,
    output spq_pkg::cmd_t   cmd
);

    typedef enum logic {
        OUT_FREE,
        OUT_HELD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign out_valid = (state_reg == OUT_HELD);
    assign in_stall  = (state_reg == OUT_HELD) && out_stall;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        cmd.load   = accept;
        cmd.insert = 1'b0;
        cmd.remove = 1'b0;
        if (mode == spq_pkg::MODE_INSERT)
        begin
            if (flags.full)
            begin
                cmd.status = spq_pkg::STATUS_FULL;
            end
            else
            begin
                cmd.status = spq_pkg::STATUS_INSERTED;
                cmd.insert = accept;
            end
        end
        else
        begin
            if (flags.empty)
            begin
                cmd.status = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                cmd.status = spq_pkg::STATUS_REMOVED;
                cmd.remove = accept;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = OUT_HELD;
        end
        else if (!out_stall)
        begin
            state_next = OUT_FREE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= OUT_FREE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/spq_datapath.sv =====
module spq_datapath #(
    parameter int DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spq_pkg::cmd_t                        cmd,
    input  logic [spq_pkg::IdWidth-1:0]          job_id,
    input  logic [spq_pkg::PriorityWidth-1:0]    job_priority,
    output spq_pkg::flags_t                      flags,
    output spq_pkg::status_t                     status,
    output logic [spq_pkg::IdWidth-1:0]          out_id,
    output logic [spq_pkg::PriorityWidth-1:0]    out_priority,
    output logic [spq_pkg::OccWidth-1:0]         occupancy
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [spq_pkg::IdWidth-1:0]       id_reg  [DEPTH];
    logic [spq_pkg::PriorityWidth-1:0] pri_reg [DEPTH];
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic [DEPTH-1:0]                  gt;
    logic [DEPTH-1:0]                  prev_gt;
    logic [CW+spq_pkg::OccWidth-1:0]   count_ext;

    spq_pkg::status_t                  status_reg;
    logic [spq_pkg::IdWidth-1:0]       out_id_reg;
    logic [spq_pkg::PriorityWidth-1:0] out_priority_reg;
    logic [spq_pkg::OccWidth-1:0]      occupancy_reg;

    assign flags.full  = (count_reg == CW'(DEPTH));
    assign flags.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.remove)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign count_ext = {{spq_pkg::OccWidth{1'b0}}, count_next};

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic here;

            // A held job whose priority is strictly above the new one moves back.
            assign gt[i] = (CW'(i) < count_reg) && (pri_reg[i] > job_priority);

            if (i == 0)
            begin : g_first
                assign prev_gt[i] = 1'b0;
            end
            else
            begin : g_rest
                assign prev_gt[i] = gt[i-1];
            end

            assign here = !prev_gt[i] && (gt[i] || (CW'(i) == count_reg));

            always_ff @(posedge clk)
            begin
                if (cmd.insert)
                begin
                    if (prev_gt[i])
                    begin
                        if (i > 0)
                        begin
                            id_reg[i]  <= id_reg[(i > 0) ? i - 1 : 0];
                            pri_reg[i] <= pri_reg[(i > 0) ? i - 1 : 0];
                        end
                    end
                    else if (here)
                    begin
                        id_reg[i]  <= job_id;
                        pri_reg[i] <= job_priority;
                    end
                end
                else if (cmd.remove && (i < DEPTH - 1))
                begin
                    id_reg[i]  <= id_reg[(i < DEPTH - 1) ? i + 1 : i];
                    pri_reg[i] <= pri_reg[(i < DEPTH - 1) ? i + 1 : i];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg    <= cmd.status;
            occupancy_reg <= count_ext[spq_pkg::OccWidth-1:0];
            if (cmd.remove)
            begin
                out_id_reg       <= id_reg[0];
                out_priority_reg <= pri_reg[0];
            end
            else
            begin
                out_id_reg       <= '0;
                out_priority_reg <= '0;
            end
        end
    end

    assign status       = status_reg;
    assign out_id       = out_id_reg;
    assign out_priority = out_priority_reg;
    assign occupancy    = occupancy_reg;

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the sorted priority queue.
//
// A directed table goes first. It covers a remove on an empty queue, the
// extreme ids and priorities, ties that must leave in arrival order, a fill
// to capacity, inserts rejected because the queue is full, and a full drain.
// After that come random transfers. The mix of inserts and removes changes
// from phase to phase, so the queue swings between empty and full many times.
// Every accepted input transfer runs through a behavioral copy of the queue
// in this file. The predicted result, or the one typed into a table row, is
// queued and then compared, field by field, with the next output transfer.
module testbench;

    localparam int QUEUE_DEPTH   = 8;
    localparam int RANDOM_ITEMS  = 525;
    localparam int PHASE_ITEMS   = 40;
    // The receiver's long hold-off starts once this many results have come.
    localparam int HOLD_AFTER    = 200;
    localparam int HOLD_CYCLES   = 40;
    // The sender waits for every result to come back once, at this random item.
    localparam int DRAIN_ITEM    = 380;
    // The result register is the only stage, so a few cycles are ample to
    // catch a stray result after the last expected one.
    localparam int SETTLE_CYCLES = 4;

    typedef logic [spq_pkg::IdWidth-1:0]       id_t;
    typedef logic [spq_pkg::PriorityWidth-1:0] prio_t;
    typedef logic [spq_pkg::OccWidth-1:0]      occ_t;

    // One result, laid out like the output ports.
    typedef struct packed {
        spq_pkg::status_t status;
        id_t              id;
        prio_t            prio;
        occ_t             occ;
    } result_t;

    // One job held in the behavioral queue.
    typedef struct packed {
        id_t   id;
        prio_t prio;
    } job_t;

    // One row of the directed table. Where has_typed is set, the result is
    // written into the row. Otherwise the behavioral queue supplies it.
    typedef struct packed {
        logic    op;
        id_t     id;
        prio_t   prio;
        logic    has_typed;
        result_t typed;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;

    localparam stim_row_t DIRECTED[DIRECTED_ROWS] = '{
        // A remove right after reset finds nothing to pop.
        '{spq_pkg::MODE_REMOVE, 16'h1234, 8'h56, 1'b1,
          '{spq_pkg::STATUS_EMPTY,    16'h0000, 8'h00, 4'd0}},
        // Extreme ids and priorities: the all-ones job goes in first and
        // leaves last.
        '{spq_pkg::MODE_INSERT, 16'hFFFF, 8'hFF, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd1}},
        '{spq_pkg::MODE_INSERT, 16'h0000, 8'h00, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd2}},
        '{spq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF, 1'b1,
          '{spq_pkg::STATUS_REMOVED,  16'h0000, 8'h00, 4'd1}},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b1,
          '{spq_pkg::STATUS_REMOVED,  16'hFFFF, 8'hFF, 4'd0}},
        '{spq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF, 1'b1,
          '{spq_pkg::STATUS_EMPTY,    16'h0000, 8'h00, 4'd0}},
        // Fill to capacity. There are ties at 5 and at 3, plus both extremes.
        '{spq_pkg::MODE_INSERT, 16'h0001, 8'h05, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd1}},
        '{spq_pkg::MODE_INSERT, 16'h0002, 8'h05, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd2}},
        '{spq_pkg::MODE_INSERT, 16'h0003, 8'h03, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd3}},
        '{spq_pkg::MODE_INSERT, 16'h0004, 8'hFF, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd4}},
        '{spq_pkg::MODE_INSERT, 16'h0005, 8'h00, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd5}},
        '{spq_pkg::MODE_INSERT, 16'h0006, 8'h05, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd6}},
        '{spq_pkg::MODE_INSERT, 16'h0007, 8'h80, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd7}},
        '{spq_pkg::MODE_INSERT, 16'h0008, 8'h03, 1'b1,
          '{spq_pkg::STATUS_INSERTED, 16'h0000, 8'h00, 4'd8}},
        // Inserts into a full queue are turned away and change nothing.
        '{spq_pkg::MODE_INSERT, 16'hAAAA, 8'h01, 1'b1,
          '{spq_pkg::STATUS_FULL,     16'h0000, 8'h00, 4'd8}},
        '{spq_pkg::MODE_INSERT, 16'h5555, 8'hFE, 1'b1,
          '{spq_pkg::STATUS_FULL,     16'h0000, 8'h00, 4'd8}},
        // The drain order is checked against the behavioral queue.
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'hFFFF, 8'hFF, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b0, '0},
        '{spq_pkg::MODE_REMOVE, 16'h0000, 8'h00, 1'b1,
          '{spq_pkg::STATUS_EMPTY,    16'h0000, 8'h00, 4'd0}}
    };

    logic                              clk;
    logic                              rst_n;
    logic                              in_valid;
    logic                              in_stall;
    logic                              mode;
    logic [spq_pkg::IdWidth-1:0]       job_id;
    logic [spq_pkg::PriorityWidth-1:0] job_priority;
    logic                              out_valid;
    logic                              out_stall;
    logic [spq_pkg::StatusWidth-1:0]   status;
    logic [spq_pkg::IdWidth-1:0]       out_id;
    logic [spq_pkg::PriorityWidth-1:0] out_priority;
    logic [spq_pkg::OccWidth-1:0]      occupancy;

    // These travel with the payload so that the monitor knows whether the
    // transfer it sees carries a result written into the directed table.
    logic                     item_has_typed;
    result_t                  item_typed;

    // Behavioral copy of the queue. Index 0 is the front.
    job_t    held_jobs[$];
    // Results still owed by the block, oldest first.
    result_t owed_results[$];

    int fail_count;
    int results_seen;
    int burst_left;
    int insert_count;
    int remove_count;
    int full_count;
    int empty_count;
    int peak_occupancy;

    sorted_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .job_id       (job_id),
        .job_priority (job_priority),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_id       (out_id),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Applies one operation to the behavioral queue and returns the result
    // that the block must produce for it. A new job goes after every job of
    // equal or smaller priority, so ties leave in arrival order.
    function automatic result_t apply_job_op(input logic op,
                                             input id_t id,
                                             input prio_t prio);
        result_t res;
        int      pos;
        res = '0;
        if (op == spq_pkg::MODE_INSERT)
        begin
            if (held_jobs.size() >= QUEUE_DEPTH)
            begin
                res.status = spq_pkg::STATUS_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < held_jobs.size() && held_jobs[pos].prio <= prio)
                begin
                    pos++;
                end
                held_jobs.insert(pos, '{id: id, prio: prio});
                res.status = spq_pkg::STATUS_INSERTED;
            end
        end
        else
        begin
            if (held_jobs.size() == 0)
            begin
                res.status = spq_pkg::STATUS_EMPTY;
            end
            else
            begin
                res.status = spq_pkg::STATUS_REMOVED;
                res.id     = held_jobs[0].id;
                res.prio   = held_jobs[0].prio;
                void'(held_jobs.pop_front());
            end
        end
        res.occ = occ_t'(held_jobs.size());
        return res;
    endfunction

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Offers one transfer and holds it until the block takes it. Afterward the
    // sender may take a gap when a burst ends, or it may wait until every owed
    // result has come back. The drive and the wait are the only places where
    // in_valid changes, so it gets at most one update per clock edge.
    task automatic offer_job(input logic op,
                             input id_t id,
                             input prio_t prio,
                             input logic has_typed,
                             input result_t typed,
                             input bit drain_after);
        int gap;
        in_valid       <= 1'b1;
        mode           <= op;
        job_id         <= id;
        job_priority   <= prio;
        item_has_typed <= has_typed;
        item_typed     <= typed;
        do
        begin
            @(posedge clk);
        end
        while (!(in_valid && !in_stall));

        gap = 0;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            // About a third of the bursts run straight into the next one.
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (drain_after || gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain_after)
            begin
                do
                begin
                    @(posedge clk);
                end
                while (owed_results.size() != 0);
            end
        end
    endtask

    // Sender. It applies reset, walks the directed table and then runs the
    // random phases. Each random phase favors inserts or removes or mixes them
    // evenly, so the queue keeps reaching the full and the empty condition. Most
    // priorities come from a narrow range, which makes ties common.
    initial
    begin
        int    insert_pct;
        logic  op;
        prio_t prio;
        int    pick;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = spq_pkg::MODE_INSERT;
        job_id         = '0;
        job_priority   = '0;
        item_has_typed = 1'b0;
        item_typed     = '0;
        fail_count     = 0;
        results_seen   = 0;
        burst_left     = $urandom_range(1, 24);
        insert_pct     = 50;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIRECTED_ROWS; row++)
        begin
            offer_job(DIRECTED[row].op, DIRECTED[row].id, DIRECTED[row].prio,
                      DIRECTED[row].has_typed, DIRECTED[row].typed, 1'b0);
        end

        for (int item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (item % PHASE_ITEMS == 0)
            begin
                case ($urandom_range(0, 4))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    2: insert_pct = 50;
                    3: insert_pct = 95;
                    default: insert_pct = 5;
                endcase
            end
            op   = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                        : spq_pkg::MODE_REMOVE;
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                prio = prio_t'($urandom_range(0, 7));
            end
            else if (pick < 8)
            begin
                prio = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            else
            begin
                prio = prio_t'($urandom_range(0, 255));
            end
            offer_job(op, id_t'($urandom_range(0, 65535)), prio, 1'b0, '0,
                      item == DRAIN_ITEM);
        end

        // At the end, wait until every owed result has arrived. Then watch a
        // few more cycles so that a stray result would still be caught.
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (owed_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d removes, %0d full rejects, %0d empty rejects.",
                 insert_count, remove_count, full_count, empty_count);
        $display("Peak occupancy was %0d of %0d, with %0d results checked.",
                 peak_occupancy, QUEUE_DEPTH, results_seen);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // Receiver. The stall rate changes from one random span to the next, and some
    // stretches have no stall at all. Once, after enough results, the
    // receiver holds off for a long stretch while the sender keeps offering
    // transfers. The result register then stays full and the input stalls.
    initial
    begin
        int  stall_pct;
        int  span_left;
        bit  held_off;

        out_stall = 1'b0;
        stall_pct = 0;
        span_left = 0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_off && results_seen >= HOLD_AFTER)
            begin
                held_off = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (span_left == 0)
                begin
                    span_left = $urandom_range(16, 80);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                span_left--;
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Monitor. Every signal is sampled at the rising edge, before this edge's
    // updates take effect. An input transfer is predicted first, and an output
    // transfer is checked second. This order holds even if a result could
    // leave in the same cycle as its item.
    always @(posedge clk)
    begin
        result_t predicted;
        result_t owed;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = apply_job_op(mode, job_id, job_priority);
                case (predicted.status)
                    spq_pkg::STATUS_INSERTED: insert_count++;
                    spq_pkg::STATUS_REMOVED:  remove_count++;
                    spq_pkg::STATUS_FULL:     full_count++;
                    default:                  empty_count++;
                endcase
                if (int'(predicted.occ) > peak_occupancy)
                begin
                    peak_occupancy = int'(predicted.occ);
                end
                owed_results.push_back(item_has_typed ? item_typed : predicted);
            end
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none expected, actual status %0h",
                             $time, status);
                    $display("    id %0h prio %0h occ %0d",
                             out_id, out_priority, occupancy);
                    fail_count++;
                end
                else
                begin
                    owed = owed_results.pop_front();
                    report_field("status",       int'(owed.status), int'(status));
                    report_field("out_id",       int'(owed.id),     int'(out_id));
                    report_field("out_priority", int'(owed.prio),   int'(out_priority));
                    report_field("occupancy",    int'(owed.occ),    int'(occupancy));
                end
            end
        end
    end

    // Stops a run that hangs. The limit is far longer than the slowest
    // correct run needs, even with every stall and gap at its longest.
    initial
    begin
        #2000000;
        $display("Timeout with %0d results still owed.", owed_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sorted_priority_queue.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_controller.sv
rtl/core/spq_datapath.sv
rtl/core/sorted_priority_queue.sv
verif/testbench.sv
